// ===== rtl/core/appliance_uart_frame_relay_assert.svh =====
// Assertion macros for the checker of the frame relay.
// No dependencies; each macro expands to one concurrent assertion.
`ifndef APPLIANCE_UART_FRAME_RELAY_ASSERT_SVH
`define APPLIANCE_UART_FRAME_RELAY_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define AFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame relay assertion failed");

// next-cycle implication, disabled while reset is asserted
`define AFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame relay assertion failed");

`endif

// ===== rtl/core/afr_pkg.sv =====
// Types and constants of the appliance UART frame relay.
// No dependencies; used by the interfaces, the top level and the checker.
package afr_pkg;

    localparam int unsigned PANEL_FRAME_LEN = 10;
    localparam int unsigned BOARD_FRAME_LEN = 15;
    localparam int unsigned IDX_W           = 4;
    localparam int unsigned RAM_DEPTH       = 2 * (1 << IDX_W);
    localparam int unsigned CAP_DEPTH       = BOARD_FRAME_LEN - 1;

    localparam logic [IDX_W-1:0] PANEL_LAST = IDX_W'(PANEL_FRAME_LEN - 1);
    localparam logic [IDX_W-1:0] BOARD_LAST = IDX_W'(BOARD_FRAME_LEN - 1);

    // byte positions inside a frame
    localparam logic [IDX_W-1:0] BI_HDR0   = 4'd0;
    localparam logic [IDX_W-1:0] BI_HDR1   = 4'd1;
    localparam logic [IDX_W-1:0] BI_POWER  = 4'd2;
    localparam logic [IDX_W-1:0] BI_FAN    = 4'd3;
    localparam logic [IDX_W-1:0] BI_HUMID  = 4'd4;
    localparam logic [IDX_W-1:0] BI_TARGET = 4'd5;
    localparam logic [IDX_W-1:0] BI_TIMER  = 4'd6;
    localparam logic [IDX_W-1:0] BI_FLAGS  = 4'd7;
    localparam logic [IDX_W-1:0] BI_CTRL   = 4'd8;
    localparam logic [IDX_W-1:0] BI_WATER  = 4'd9;
    localparam logic [IDX_W-1:0] BI_TEMP   = 4'd10;
    localparam logic [IDX_W-1:0] BI_MINUTE = 4'd13;

    localparam logic [7:0] HDR_FIRST_RST  = 8'hbb;
    localparam logic [7:0] HDR_SECOND_RST = 8'h51;
    localparam logic [7:0] TIMER_ACTIVE   = 8'hb0;
    localparam logic [7:0] CTRL_CLR_MASK  = 8'hfd;
    localparam logic [14:0] HUMID_SCALE   = 15'd100;

    localparam logic PORT_PANEL = 1'b0;
    localparam logic PORT_BOARD = 1'b1;

    localparam logic CFG_HDR_FIRST  = 1'b0;
    localparam logic CFG_HDR_SECOND = 1'b1;

    localparam logic [1:0] FS_GOOD = 2'd0;
    localparam logic [1:0] FS_CSUM = 2'd1;
    localparam logic [1:0] FS_HDR  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_ERR,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       source_port;
        logic       restart;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        dest_port;
        logic        last;
        logic [1:0]  frame_status;
        logic        power_on;
        logic        fan_high;
        logic [14:0] humidity;
        logic [7:0]  target_code;
        logic [7:0]  temperature;
        logic [4:0]  timer_hours;
        logic [7:0]  timer_minutes;
        logic [3:0]  flag_set;
    } t_out_item;

endpackage

// ===== rtl/core/afr_in_if.sv =====
// Valid/ready channel carrying received bytes into the frame relay.
// Depends on afr_pkg for the payload type.
interface afr_in_if;
    logic               valid;
    logic               ready;
    afr_pkg::t_in_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/afr_out_if.sv =====
// Valid/ready channel carrying forwarded bytes and status out of the frame relay.
// Depends on afr_pkg for the payload type.
interface afr_out_if;
    logic               valid;
    logic               ready;
    afr_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/afr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module afr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/appliance_uart_frame_relay.sv =====
// Frame relay between a display panel UART link and a main board UART link.
// Channels: in_ch (sink) takes one received byte per transaction, tagged with
// its source port and an optional restart that drops that port's partial frame.
// out_ch (source) gives forwarded bytes to the opposite port, each carrying the
// decoded appliance status after the frame's update; a bad frame gives a single
// error transaction with out_byte 0.
// Sequence: a byte that does not complete a frame, or a restart, is taken in idle.
// A completing byte starts a read-back of the frame from the buffer RAM, one
// byte per cycle, then a decision state, then a read state and a load state per
// forwarded byte through the single read port, the load waiting while out_ch
// stalls; a bad frame goes from the decision state to one error transaction.
// Configuration: i_cfg_we writes header_first (index 0) or header_second
// (index 1) in the cycle it is high.
// Reset clears counts, sums and output valid, and sets headers and status to
// defaults; the frame RAM is not cleared: each entry is written before it is read.
// When out_ch stalls, the output register holds its transaction; the block
// still takes input bytes while idle, but waits to load the next result.
module appliance_uart_frame_relay (
    input  logic       i_clk,
    input  logic       i_rst_n,
    afr_in_if.sink     in_ch,
    afr_out_if.source  out_ch,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data
);
    import afr_pkg::*;

    localparam int unsigned RAM_AW = $clog2(RAM_DEPTH);

    t_state r_state, n_state;

    logic [7:0]       r_hdr0, r_hdr1;
    logic [IDX_W-1:0] r_cnt [2];
    logic [7:0]       r_sum [2];
    logic             r_port;
    logic [7:0]       r_csum;
    logic [7:0]       r_last_byte;
    logic [IDX_W-1:0] r_ridx, r_didx;
    logic             r_dvld;
    logic [7:0]       r_cap [CAP_DEPTH];

    logic             r_power, r_fan, r_just;
    logic [14:0]      r_humid;
    logic [7:0]       r_target, r_temp, r_minute;
    logic [4:0]       r_timer;
    logic [2:0]       r_flags;

    logic             r_out_vld;
    t_out_item        r_out;

    // combinational control
    logic             w_in_acc, w_out_free, w_load, w_ram_re, w_last_emit;
    logic [IDX_W-1:0] w_len_m1, w_idx;
    logic [7:0]       w_new_sum, w_rdata, w_emit_byte;
    logic [1:0]       w_status;
    t_out_item        w_item;

    assign w_in_acc   = in_ch.valid && in_ch.ready;
    assign w_out_free = !r_out_vld || out_ch.ready;

    // length of the frame in flight (scan/emit) or of the arriving byte's port
    always_comb begin
        logic sel;
        sel = (r_state == ST_IDLE) ? in_ch.payload.source_port : r_port;
        w_len_m1 = (sel == PORT_BOARD) ? BOARD_LAST : PANEL_LAST;
    end

    assign w_idx     = r_cnt[in_ch.payload.source_port];
    assign w_new_sum = (w_idx >= IDX_W'(2) && w_idx < w_len_m1)
                     ? r_sum[in_ch.payload.source_port] + in_ch.payload.rx_byte
                     : r_sum[in_ch.payload.source_port];

    assign w_status = (r_csum != r_last_byte) ? FS_CSUM
                    : (r_cap[BI_HDR0] != r_hdr0 || r_cap[BI_HDR1] != r_hdr1) ? FS_HDR
                    : FS_GOOD;

    assign w_last_emit = (r_ridx == w_len_m1);
    always_comb begin
        if (w_last_emit) begin
            w_emit_byte = r_csum;
        end else if (r_port == PORT_BOARD && r_ridx == BI_CTRL) begin
            w_emit_byte = w_rdata & CTRL_CLR_MASK;
        end else begin
            w_emit_byte = w_rdata;
        end
    end

    // next state and control
    always_comb begin
        n_state  = r_state;
        in_ch.ready = 1'b0;
        w_ram_re = 1'b0;
        w_load   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                in_ch.ready = 1'b1;
                if (in_ch.valid && !in_ch.payload.restart && w_idx == w_len_m1) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                w_ram_re = (r_ridx < w_len_m1);
                if (r_dvld && r_didx == w_len_m1 - IDX_W'(1)) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_state = (w_status == FS_GOOD) ? ST_EMIT_RD : ST_ERR;
            end
            ST_ERR: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT_RD: begin
                w_ram_re = !w_last_emit;
                n_state  = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = w_last_emit ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    afr_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && !in_ch.payload.restart),
        .i_waddr ({in_ch.payload.source_port, w_idx}),
        .i_wdata (in_ch.payload.rx_byte),
        .i_re    (w_ram_re),
        .i_raddr (RAM_AW'({r_port, r_ridx})),
        .o_rdata (w_rdata)
    );

    // result item: good byte or error transaction
    always_comb begin
        w_item               = '0;
        w_item.dest_port     = !r_port;
        w_item.power_on      = r_power;
        w_item.fan_high      = r_fan;
        w_item.humidity      = r_humid;
        w_item.target_code   = r_target;
        w_item.temperature   = r_temp;
        w_item.timer_hours   = r_timer;
        w_item.timer_minutes = r_minute;
        if (r_state == ST_ERR) begin
            w_item.out_byte     = 8'd0;
            w_item.last         = 1'b1;
            w_item.frame_status = (r_csum != r_last_byte) ? FS_CSUM : FS_HDR;
            w_item.flag_set     = {1'b0, r_flags};
        end else begin
            w_item.out_byte     = w_emit_byte;
            w_item.last         = w_last_emit;
            w_item.frame_status = FS_GOOD;
            w_item.flag_set     = {r_just, r_flags};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_hdr0    <= HDR_FIRST_RST;
            r_hdr1    <= HDR_SECOND_RST;
            r_cnt[0]  <= '0;
            r_cnt[1]  <= '0;
            r_sum[0]  <= '0;
            r_sum[1]  <= '0;
            r_dvld    <= 1'b0;
            r_power   <= 1'b0;
            r_fan     <= 1'b1;
            r_just    <= 1'b0;
            r_humid   <= '0;
            r_target  <= '0;
            r_temp    <= '0;
            r_minute  <= '0;
            r_timer   <= '0;
            r_flags   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_HDR_FIRST) begin
                    r_hdr0 <= i_cfg_data;
                end else begin
                    r_hdr1 <= i_cfg_data;
                end
            end

            if (w_in_acc) begin
                if (in_ch.payload.restart) begin
                    r_cnt[in_ch.payload.source_port] <= '0;
                    r_sum[in_ch.payload.source_port] <= '0;
                end else if (w_idx == w_len_m1) begin
                    r_cnt[in_ch.payload.source_port] <= '0;
                    r_sum[in_ch.payload.source_port] <= '0;
                    r_port      <= in_ch.payload.source_port;
                    r_csum      <= w_new_sum;
                    r_last_byte <= in_ch.payload.rx_byte;
                    r_ridx      <= '0;
                end else begin
                    r_cnt[in_ch.payload.source_port] <= w_idx + IDX_W'(1);
                    r_sum[in_ch.payload.source_port] <= w_new_sum;
                end
            end

            // read-back pipeline: address issued, data registered by the RAM in the next cycle
            r_dvld <= (r_state == ST_SCAN) && w_ram_re;
            if (r_state == ST_SCAN && w_ram_re) begin
                r_didx <= r_ridx;
                r_ridx <= r_ridx + IDX_W'(1);
            end
            if (r_dvld) begin
                r_cap[r_didx] <= w_rdata;
            end

            if (r_state == ST_DECIDE) begin
                r_ridx <= '0;
                // pairing start only on a good panel frame
                r_just <= (w_status == FS_GOOD) && (r_port == PORT_PANEL)
                          && r_cap[BI_FLAGS][1] && !r_flags[2];
                if (w_status == FS_GOOD) begin
                    r_power <= r_cap[BI_POWER][7];
                    r_fan   <= r_cap[BI_FAN][5];
                    if (r_port == PORT_PANEL) begin
                        r_flags[2] <= r_cap[BI_FLAGS][1];
                    end else begin
                        r_humid    <= {7'd0, r_cap[BI_HUMID]} * HUMID_SCALE;
                        r_target   <= r_cap[BI_TARGET];
                        r_temp     <= r_cap[BI_TEMP];
                        r_flags[0] <= r_cap[BI_FLAGS][7];
                        r_flags[1] <= r_cap[BI_WATER][2];
                        if ((r_cap[BI_TIMER] & TIMER_ACTIVE) != 8'd0) begin
                            r_timer  <= r_cap[BI_TIMER][4:0];
                            r_minute <= r_cap[BI_MINUTE];
                        end else begin
                            r_timer <= '0;
                        end
                        // clearing control bit 1 lowers the checksum by two
                        if (r_cap[BI_CTRL][1]) begin
                            r_csum <= r_csum - 8'd2;
                        end
                    end
                end
            end

            if (r_state == ST_EMIT_LD && w_load && !w_last_emit) begin
                r_ridx <= r_ridx + IDX_W'(1);
            end

            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (out_ch.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_item;
        end
    end

    assign out_ch.valid   = r_out_vld;
    assign out_ch.payload = r_out;
endmodule

// ===== rtl/core/afr_checker.sv =====
// Port-level checker for the appliance UART frame relay, bound to the top level.
// Depends on afr_pkg and appliance_uart_frame_relay_assert.svh.
`include "appliance_uart_frame_relay_assert.svh"

module afr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last,
    input logic [1:0] i_out_status,
    input logic [3:0] i_out_flags,
    input afr_pkg::t_out_item i_out_payload
);
    import afr_pkg::*;

    // an error transaction is a single zero byte that closes the input's results
    `AFR_ASSERT_IMP(a_err_single, i_clk, i_rst_n, i_out_valid && (i_out_status != FS_GOOD), (i_out_byte == 8'd0) && i_out_last)
    // pairing-start flag only rides on good frames
    `AFR_ASSERT_IMP(a_err_no_pair, i_clk, i_rst_n, i_out_valid && (i_out_status != FS_GOOD), !i_out_flags[3])
    // while a frame is being forwarded no new byte is taken
    `AFR_ASSERT_IMP(a_busy_forward, i_clk, i_rst_n, i_out_valid && !i_out_last && (i_out_status == FS_GOOD), !i_in_ready)
    // a stalled transaction holds
    `AFR_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_payload))
endmodule

bind appliance_uart_frame_relay afr_checker u_afr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (in_ch.ready),
    .i_out_valid   (out_ch.valid),
    .i_out_ready   (out_ch.ready),
    .i_out_byte    (out_ch.payload.out_byte),
    .i_out_last    (out_ch.payload.last),
    .i_out_status  (out_ch.payload.frame_status),
    .i_out_flags   (out_ch.payload.flag_set),
    .i_out_payload (out_ch.payload)
);

// ===== sim/appliance_uart_frame_relay_test.sv =====
// Self-checking testbench of appliance_uart_frame_relay: frames on both UART ports,
// header settings, restarts and noise, checked against a built-in status/forwarding model.
// Depends on afr_pkg, afr_in_if and afr_out_if from the RTL.
module appliance_uart_frame_relay_test;
    timeunit 1ns;
    timeprecision 1ps;

    import afr_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int MAX_PRINTED    = 30;

    typedef enum {FK_GOOD, FK_CSUM, FK_HDR} t_frame_kind;
    typedef t_in_item t_item_q [$];

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [7:0] i_cfg_data;

    afr_in_if  in_ch();
    afr_out_if out_ch();

    appliance_uart_frame_relay DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // model state: headers, per-port frame collection, decoded status
    logic [7:0] hdr_first  = HDR_FIRST_RST;
    logic [7:0] hdr_second = HDR_SECOND_RST;
    logic [7:0] frame_buf [2][15];
    int         fill_cnt [2] = '{0, 0};
    logic [7:0] run_sum [2]  = '{8'h00, 8'h00};
    logic       st_power  = 1'b0;
    logic       st_fan    = 1'b1;
    logic [7:0] st_humid  = 8'h00;
    logic [7:0] st_target = 8'h00;
    logic [7:0] st_temp   = 8'h00;
    logic [4:0] st_timer  = 5'd0;
    logic [7:0] st_minute = 8'h00;
    logic [2:0] st_flags  = 3'd0;

    t_out_item forward_queue [$];

    int   mismatch_count = 0;
    int   bytes_sent     = 0;
    int   stalled_cycles = 0;
    int   hold_left      = 0;
    logic full_rate      = 1'b0;
    logic moved;

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("MISMATCH at %0t ns: %s", $time, what);
        end
    endtask

    function automatic t_out_item status_item(input logic [7:0] b, input logic dest,
                                              input logic lst, input logic [1:0] fs,
                                              input logic jp);
        t_out_item r;
        r.out_byte      = b;
        r.dest_port     = dest;
        r.last          = lst;
        r.frame_status  = fs;
        r.power_on      = st_power;
        r.fan_high      = st_fan;
        r.humidity      = 15'(st_humid) * HUMID_SCALE;
        r.target_code   = st_target;
        r.temperature   = st_temp;
        r.timer_hours   = st_timer;
        r.timer_minutes = st_minute;
        r.flag_set      = {jp, st_flags};
        return r;
    endfunction

    // collect one byte; on frame completion check it, update status, queue what goes out
    task automatic decode_and_forward(input t_in_item it);
        logic       port;
        int         flen;
        int         pos;
        logic [7:0] s;
        logic [7:0] c;
        logic [1:0] fs;
        logic       just;
        port = it.source_port;
        flen = (port == PORT_BOARD) ? BOARD_FRAME_LEN : PANEL_FRAME_LEN;
        just = 1'b0;
        if (it.restart) begin
            fill_cnt[port] = 0;
            run_sum[port]  = 8'h00;
            return;
        end
        pos = fill_cnt[port];
        if (pos >= flen) pos = 0;
        frame_buf[port][pos] = it.rx_byte;
        if (pos >= 2 && pos <= flen - 2) run_sum[port] += it.rx_byte;
        if (pos + 1 < flen) begin
            fill_cnt[port] = pos + 1;
            return;
        end
        s = run_sum[port];
        fill_cnt[port] = 0;
        run_sum[port]  = 8'h00;

        if (s != frame_buf[port][flen-1]) fs = FS_CSUM;
        else if (frame_buf[port][BI_HDR0] != hdr_first ||
                 frame_buf[port][BI_HDR1] != hdr_second) fs = FS_HDR;
        else fs = FS_GOOD;
        if (fs != FS_GOOD) begin
            forward_queue.push_back(status_item(8'h00, ~port, 1'b1, fs, 1'b0));
            return;
        end

        st_power = frame_buf[port][BI_POWER][7];
        st_fan   = frame_buf[port][BI_FAN][5];
        if (port == PORT_PANEL) begin
            just        = frame_buf[port][BI_FLAGS][1] & ~st_flags[2];
            st_flags[2] = frame_buf[port][BI_FLAGS][1];
        end else begin
            st_humid  = frame_buf[port][BI_HUMID];
            st_target = frame_buf[port][BI_TARGET];
            st_temp   = frame_buf[port][BI_TEMP];
            if ((frame_buf[port][BI_TIMER] & TIMER_ACTIVE) != 8'h00) begin
                st_timer  = frame_buf[port][BI_TIMER][4:0];
                st_minute = frame_buf[port][BI_MINUTE];
            end else begin
                st_timer = 5'd0;
            end
            st_flags[0] = frame_buf[port][BI_FLAGS][7];
            st_flags[1] = frame_buf[port][BI_WATER][2];
            // control bit gets cleared, checksum rebuilt before forwarding
            if (frame_buf[port][BI_CTRL][1]) begin
                frame_buf[port][BI_CTRL] &= CTRL_CLR_MASK;
                c = 8'h00;
                for (int i = 2; i < flen - 1; i++) c += frame_buf[port][i];
                frame_buf[port][flen-1] = c;
            end
        end
        for (int i = 0; i < flen; i++) begin
            forward_queue.push_back(status_item(frame_buf[port][i], ~port,
                                                i == flen - 1, FS_GOOD, just));
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    task automatic compare_result(input t_out_item got, input t_out_item want);
        check_field("out_byte",      got.out_byte,      want.out_byte);
        check_field("dest_port",     got.dest_port,     want.dest_port);
        check_field("last",          got.last,          want.last);
        check_field("frame_status",  got.frame_status,  want.frame_status);
        check_field("power_on",      got.power_on,      want.power_on);
        check_field("fan_high",      got.fan_high,      want.fan_high);
        check_field("humidity",      got.humidity,      want.humidity);
        check_field("target_code",   got.target_code,   want.target_code);
        check_field("temperature",   got.temperature,   want.temperature);
        check_field("timer_hours",   got.timer_hours,   want.timer_hours);
        check_field("timer_minutes", got.timer_minutes, want.timer_minutes);
        check_field("flag_set",      got.flag_set,      want.flag_set);
    endtask

    // output side: checks results, models input transactions, runs the watchdog
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            moved = 1'b0;
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                moved = 1'b1;
                if (forward_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, byte %0h",
                                              out_ch.payload.out_byte));
                end else begin
                    compare_result(out_ch.payload, forward_queue.pop_front());
                end
            end
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
                moved = 1'b1;
                decode_and_forward(in_ch.payload);
            end
            stalled_cycles = moved ? 0 : stalled_cycles + 1;
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // receiver back-pressure in short random bursts
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end else if (!full_rate && $urandom_range(0, 5) == 0) begin
            out_ch.ready <= 1'b0;
            hold_left = $urandom_range(1, 3) - 1;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    function automatic t_in_item make_item(input logic [7:0] b, input logic port,
                                           input logic rs);
        t_in_item it;
        it.rx_byte     = b;
        it.source_port = port;
        it.restart     = rs;
        return it;
    endfunction

    // fill < 0 gives random payload bytes, otherwise every payload byte is fill
    function automatic t_item_q frame_items(input logic port, input t_frame_kind kind,
                                            input int fill);
        t_item_q    q;
        logic [7:0] fb [15];
        logic [7:0] csum;
        int         flen;
        int         pick;
        flen = (port == PORT_BOARD) ? BOARD_FRAME_LEN : PANEL_FRAME_LEN;
        csum = 8'h00;
        for (int i = 2; i < flen - 1; i++) begin
            fb[i] = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
        end
        if (fill < 0 && port == PORT_BOARD && $urandom_range(0, 2) == 0) begin
            fb[BI_TIMER] &= ~TIMER_ACTIVE;
        end
        for (int i = 2; i < flen - 1; i++) csum += fb[i];
        fb[BI_HDR0]  = hdr_first;
        fb[BI_HDR1]  = hdr_second;
        fb[flen-1]   = csum;
        if (kind == FK_CSUM) begin
            fb[flen-1] ^= 8'($urandom_range(1, 255));
        end else if (kind == FK_HDR) begin
            pick = $urandom_range(0, 2);
            if (pick != 1) fb[BI_HDR0] ^= 8'($urandom_range(1, 255));
            if (pick != 0) fb[BI_HDR1] ^= 8'($urandom_range(1, 255));
        end
        for (int i = 0; i < flen; i++) q.push_back(make_item(fb[i], port, 1'b0));
        return q;
    endfunction

    task automatic send_item(input t_in_item it);
        if (!full_rate && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        bytes_sent++;
    endtask

    task automatic send_items(input t_item_q q);
        foreach (q[i]) send_item(q[i]);
    endtask

    // drop valid and wait until every predicted result has come out
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (forward_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_headers(input logic [7:0] first, input logic [7:0] second);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_HDR_FIRST;
        i_cfg_data <= first;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_HDR_SECOND;
        i_cfg_data <= second;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        hdr_first  = first;
        hdr_second = second;
    endtask

    task automatic random_traffic(input int nbytes);
        t_item_q qa;
        t_item_q qb;
        t_item_q q;
        int      goal;
        int      r;
        int      n;
        logic    port;
        goal = bytes_sent + nbytes;
        while (bytes_sent < goal) begin
            r    = $urandom_range(0, 99);
            port = 1'($urandom_range(0, 1));
            q    = {};
            if (r < 35) begin
                q = frame_items(port, FK_GOOD, -1);
            end else if (r < 50) begin
                // good frames on both ports, bytes interleaved
                qa = frame_items(PORT_PANEL, FK_GOOD, -1);
                qb = frame_items(PORT_BOARD, FK_GOOD, -1);
                while (qa.size() != 0 || qb.size() != 0) begin
                    if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(0, 1) == 1))
                        q.push_back(qa.pop_front());
                    else
                        q.push_back(qb.pop_front());
                end
            end else if (r < 60) begin
                q = frame_items(port, FK_CSUM, -1);
            end else if (r < 70) begin
                q = frame_items(port, FK_HDR, -1);
            end else if (r < 82 || r >= 95) begin
                q = frame_items(port, FK_GOOD, -1);
                n = $urandom_range(1, q.size() - 1);
                q = q[0:n-1];
                // mostly cut short by a restart, now and then left dangling
                if (r < 82) q.push_back(make_item(8'($urandom_range(0, 255)), port, 1'b1));
            end else if (r < 88) begin
                q.push_back(make_item(8'($urandom_range(0, 255)), port, 1'b1));
            end else begin
                repeat ($urandom_range(1, 5))
                    q.push_back(make_item(8'($urandom_range(0, 255)), port, 1'b0));
                q.push_back(make_item(8'($urandom_range(0, 255)), port, 1'b1));
            end
            send_items(q);
        end
    endtask

    // reset headers: all-ones board frame (control bit, timer, extremes),
    // panel partial cut by restart, all-zero panel frame with bad checksum
    task automatic test_directed_frames();
        t_item_q q;
        send_items(frame_items(PORT_BOARD, FK_GOOD, 8'hff));
        q = frame_items(PORT_PANEL, FK_GOOD, -1);
        send_items(q[0:2]);
        send_item(make_item(8'h00, PORT_PANEL, 1'b1));
        send_items(frame_items(PORT_PANEL, FK_CSUM, 8'h00));
    endtask

    task automatic test_header_settings();
        logic [7:0] firsts [4];
        logic [7:0] seconds [4];
        firsts  = '{8'h00, 8'hff, 8'($urandom_range(0, 255)), HDR_FIRST_RST};
        seconds = '{8'h00, 8'hff, 8'($urandom_range(0, 255)), HDR_SECOND_RST};
        for (int k = 0; k < 4; k++) begin
            wait_idle();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            write_headers(firsts[k], seconds[k]);
            random_traffic(40);
        end
    endtask

    task automatic test_full_rate_tail();
        full_rate = 1'b1;
        random_traffic(40);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_HDR_FIRST;
        i_cfg_data    = 8'h00;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_frames();
        test_header_settings();
        test_full_rate_tail();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
